FILE: rtl/core/bmma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmma_pkg
// Shared widths, the block-size reset value and the issue tag of the block matrix
// multiply-accumulate core.
// ----------------------------------------------------------------------------
package bmma_pkg;

  localparam int ELEM_W = 16;
  localparam int ACC_W  = 32;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 4'd8;

  // tag that travels with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ctl_t;

endpackage

FILE: rtl/core/bmma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmma_in_if / bmma_out_if
// Valid/ready channels for the operand words and the result words.
// ----------------------------------------------------------------------------
interface bmma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bmma_pkg::ELEM_W-1:0]  a_elem;
  logic signed [bmma_pkg::ELEM_W-1:0]  b_elem;
  logic                                clear_first;
  logic                                emit;

  modport source (output valid, a_elem, b_elem, clear_first, emit, input ready);
  modport sink   (input valid, a_elem, b_elem, clear_first, emit, output ready);
endinterface

interface bmma_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bmma_pkg::ACC_W-1:0]   c_elem;
  logic                                c_last;

  modport source (output valid, c_elem, c_last, input ready);
  modport sink   (input valid, c_elem, c_last, output ready);
endinterface

FILE: rtl/core/bmma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmma_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bmma_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmma_seq
// Index sequencer: walks i, j, k of the block product and issues one
// operand address pair per cycle, plus the accumulator address.
// ----------------------------------------------------------------------------
module bmma_seq #(
  parameter int BLOCK = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [$clog2(BLOCK+1)-1:0] n,
  output bmma_pkg::ctl_t       tag,
  output logic [((BLOCK*BLOCK > 1) ? $clog2(BLOCK*BLOCK) : 1)-1:0] a_addr,
  output logic [((BLOCK*BLOCK > 1) ? $clog2(BLOCK*BLOCK) : 1)-1:0] b_addr,
  output logic [((BLOCK*BLOCK > 1) ? $clog2(BLOCK*BLOCK) : 1)-1:0] c_addr,
  output logic                 done
);

  localparam int DEPTH = BLOCK * BLOCK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(BLOCK + 1);
  localparam int CW    = (BLOCK > 1) ? $clog2(BLOCK) : 1;

  logic          run;
  logic [CW-1:0] i, j, k;
  logic [AW-1:0] row_base;
  logic          kend, jend, iend;

  assign kend = (NW'(k) + NW'(1)) == n;
  assign jend = (NW'(j) + NW'(1)) == n;
  assign iend = (NW'(i) + NW'(1)) == n;

  assign tag.valid = run;
  assign tag.first = (k == '0);
  assign tag.last  = kend;
  assign done      = run && kend && jend && iend;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i        <= '0;
      j        <= '0;
      k        <= '0;
      row_base <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
      c_addr   <= '0;
    end else if (run) begin
      if (!kend) begin
        k      <= k + CW'(1);
        a_addr <= a_addr + AW'(1);
        b_addr <= b_addr + AW'(n);
      end else begin
        k      <= '0;
        c_addr <= c_addr + AW'(1);
        if (!jend) begin
          j      <= j + CW'(1);
          a_addr <= row_base;
          b_addr <= AW'(j) + AW'(1);
        end else begin
          j        <= '0;
          i        <= i + CW'(1);
          row_base <= row_base + AW'(n);
          a_addr   <= row_base + AW'(n);
          b_addr   <= '0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/bmma_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmma_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a 32-bit
// wrapping accumulator seeded from the old accumulator element or zero.
// ----------------------------------------------------------------------------
module bmma_mac #(
  parameter int AW = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bmma_pkg::ctl_t                       tag_in,
  input  logic [AW-1:0]                        addr_in,
  input  logic                                 keep_in,
  input  logic signed [bmma_pkg::ELEM_W-1:0]   a,
  input  logic signed [bmma_pkg::ELEM_W-1:0]   b,
  input  logic [bmma_pkg::ACC_W-1:0]           acc_old,
  output logic                                 we,
  output logic [AW-1:0]                        waddr,
  output logic [bmma_pkg::ACC_W-1:0]           wdata,
  output logic                                 busy
);

  bmma_pkg::ctl_t                    s1_tag, s2_tag, s3_tag;
  logic [AW-1:0]                     s1_addr, s2_addr, s3_addr;
  logic                              s1_keep;
  logic signed [bmma_pkg::ACC_W-1:0] prod;
  logic [bmma_pkg::ACC_W-1:0]        base;
  logic [bmma_pkg::ACC_W-1:0]        acc_sum;

  // stage 1 lines up with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s1_tag <= tag_in;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr_in;
    s1_keep <= keep_in;
    s2_addr <= s1_addr;
    prod    <= bmma_pkg::ACC_W'(a) * bmma_pkg::ACC_W'(b);
    base    <= s1_keep ? acc_old : '0;
    s3_addr <= s2_addr;
    if (s2_tag.valid) begin
      if (s2_tag.first) begin
        acc_sum <= base + bmma_pkg::ACC_W'(prod);
      end else begin
        acc_sum <= acc_sum + bmma_pkg::ACC_W'(prod);
      end
    end
  end

  assign we    = s3_tag.valid && s3_tag.last;
  assign waddr = s3_addr;
  assign wdata = acc_sum;
  assign busy  = s1_tag.valid || s2_tag.valid || s3_tag.valid;

endmodule

FILE: rtl/core/block_matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate
// Square block multiply-accumulate: C = A x B or C = C + A x B, optional
// row-major stream-out of C.
// ----------------------------------------------------------------------------
// Operand words are taken one per cycle, n*n of them per batch (n is the
// block_size register, 0 read as 1 and clipped to BLOCK). The last word of a
// batch starts the product; no word is taken until the batch is finished.
// One shared multiply-accumulate unit does all n*n*n products, one per
// cycle, and then its pipeline drains; when emit is set, the n*n accumulator
// words then leave through the single accumulator read port, each word read
// in ST_EMRD and registered in ST_EMLD; a read waits while the result
// register still holds a word not yet taken.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate #(
  parameter int BLOCK = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bmma_pkg::CFG_W-1:0]  cfg_data,
  bmma_in_if.sink                     item,
  bmma_out_if.source                  result
);

  localparam int DEPTH = BLOCK * BLOCK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(BLOCK + 1);
  localparam int TW    = 2 * NW;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_EMRD  = 3'd3;
  localparam logic [2:0] ST_EMLD  = 3'd4;

  logic [2:0]                 state;
  logic [bmma_pkg::CFG_W-1:0] block_size;
  logic [NW-1:0]              n_eff, n_run;
  logic [TW-1:0]              total, total_run;
  logic [AW-1:0]              load_index, e;
  logic                       clr_run, emit_run;
  logic                       accept, batch_end, start;
  logic [DEPTH-1:0]           acc_vld;

  bmma_pkg::ctl_t             tag;
  logic [AW-1:0]              a_addr, b_addr, c_addr, acc_raddr;
  logic                       seq_done;
  logic [bmma_pkg::ELEM_W-1:0] a_rd, b_rd;
  logic [bmma_pkg::ACC_W-1:0] acc_rd;
  logic                       mac_we, mac_busy;
  logic [AW-1:0]              mac_waddr;
  logic [bmma_pkg::ACC_W-1:0] mac_wdata;
  logic                       e_last;

  logic                       res_valid, res_last;
  logic [bmma_pkg::ACC_W-1:0] res_data;

  // effective block size
  always_comb begin
    if (block_size == '0) begin
      n_eff = NW'(1);
    end else if (block_size > bmma_pkg::CFG_W'(BLOCK)) begin
      n_eff = NW'(BLOCK);
    end else begin
      n_eff = NW'(block_size);
    end
  end

  assign total     = TW'(n_eff) * TW'(n_eff);
  assign total_run = TW'(n_run) * TW'(n_run);
  assign accept    = item.valid && item.ready;
  assign batch_end = (TW'(load_index) + TW'(1)) >= total;
  assign start     = accept && batch_end;
  assign e_last    = (TW'(e) + TW'(1)) == total_run;

  assign item.ready = (state == ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= bmma_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      block_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_index <= '0;
      e          <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (batch_end) begin
              load_index <= '0;
              state      <= ST_CALC;
            end else begin
              load_index <= load_index + AW'(1);
            end
          end
        end
        ST_CALC: begin
          if (seq_done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            e     <= '0;
            state <= emit_run ? ST_EMRD : ST_LOAD;
          end
        end
        ST_EMRD: begin
          if (!res_valid || result.ready) begin
            state <= ST_EMLD;
          end
        end
        ST_EMLD: begin
          res_valid <= 1'b1;
          e         <= e + AW'(1);
          state     <= e_last ? ST_LOAD : ST_EMRD;
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // batch flags and size, held through the product and the stream-out
  always_ff @(posedge clk) begin
    if (start) begin
      n_run    <= n_eff;
      clr_run  <= item.clear_first;
      emit_run <= item.emit;
    end
    if (state == ST_EMLD) begin
      res_data <= acc_rd;
      res_last <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (mac_we) begin
      acc_vld[mac_waddr] <= 1'b1;
    end
  end

  assign acc_raddr = (state == ST_EMRD) ? e : c_addr;

  bmma_ram #(.WIDTH(bmma_pkg::ELEM_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (load_index),
    .wdata (item.a_elem),
    .raddr (a_addr),
    .rdata (a_rd)
  );

  bmma_ram #(.WIDTH(bmma_pkg::ELEM_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (load_index),
    .wdata (item.b_elem),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  bmma_ram #(.WIDTH(bmma_pkg::ACC_W), .DEPTH(DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (mac_we),
    .waddr (mac_waddr),
    .wdata (mac_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rd)
  );

  bmma_seq #(.BLOCK(BLOCK)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .n      (n_run),
    .tag    (tag),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .c_addr (c_addr),
    .done   (seq_done)
  );

  bmma_mac #(.AW(AW)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag),
    .addr_in (c_addr),
    .keep_in (!clr_run && acc_vld[c_addr]),
    .a       (a_rd),
    .b       (b_rd),
    .acc_old (acc_rd),
    .we      (mac_we),
    .waddr   (mac_waddr),
    .wdata   (mac_wdata),
    .busy    (mac_busy)
  );

  assign result.valid  = res_valid;
  assign result.c_elem = res_data;
  assign result.c_last = res_last;

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !mac_busy)
    else $error("operand word taken while the mac pipeline is busy");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMLD) |-> !res_valid)
    else $error("result register overwritten while still held");

  a_acc_write_phase: assert property (@(posedge clk) disable iff (rst)
    mac_we |-> (state == ST_CALC || state == ST_DRAIN))
    else $error("accumulator written outside the product phase");

  a_done_drain: assert property (@(posedge clk) disable iff (rst)
    seq_done |=> (state == ST_DRAIN))
    else $error("sequencer finished without drain");

endmodule
